[rtl/mrc_pkg.sv]
// Types, constants and codes shared by the multimeter reading converter.
// Used by mrc_divider and multimeter_reading_converter_core.
`default_nettype none
package mrc_pkg;

	localparam int SAMPLE_W  = 10;
	localparam int REF_W     = 20;
	localparam int PROD_W    = 30;
	localparam int READING_W = 20;
	localparam int STEP_W    = 5;

	localparam logic [STEP_W-1:0]    DIV_STEPS  = STEP_W'(PROD_W);
	localparam logic [SAMPLE_W-1:0]  FULL_SCALE = 10'd1023;
	localparam logic [REF_W-1:0]     VOLT_GAIN  = 20'd5500;
	localparam logic [REF_W-1:0]     AMP_GAIN   = 20'd500000;
	localparam logic [READING_W-1:0] READING_MAX = 20'd999999;
	localparam logic [PROD_W-1:0]    READING_MAX_Q = 30'd999999;
	localparam logic [PROD_W-1:0]    OPEN_ABOVE = 30'd99999;
	localparam logic [PROD_W-1:0]    KILO_ABOVE = 30'd999;

	localparam logic [REF_W-1:0]    REFERENCE_RESET = 20'd10000;
	localparam logic [SAMPLE_W-1:0] CONTINUITY_RESET = 10'd50;
	localparam logic [SAMPLE_W-1:0] OPEN_LIMIT_RESET = 10'd10;

	localparam logic [1:0] REG_REFERENCE_OHMS    = 2'd0;
	localparam logic [1:0] REG_CONTINUITY_OHMS   = 2'd1;
	localparam logic [1:0] REG_OPEN_SAMPLE_LIMIT = 2'd2;

	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_VOLT = 2'd1;
	localparam logic [1:0] MODE_AMP  = 2'd2;
	localparam logic [1:0] MODE_OHM  = 2'd3;
	localparam logic [2:0] MODE_UNSEEN = 3'd4;

	localparam logic [2:0] CLASS_NONE  = 3'd0;
	localparam logic [2:0] CLASS_PLAIN = 3'd1;
	localparam logic [2:0] CLASS_SHORT = 3'd2;
	localparam logic [2:0] CLASS_OPEN  = 3'd3;
	localparam logic [2:0] CLASS_KILO  = 3'd4;
	localparam logic [2:0] CLASS_OHM   = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} mrc_state_t;

	typedef struct packed {
		logic [2:0]          switch_lines;
		logic [SAMPLE_W-1:0] voltage_sample;
		logic [SAMPLE_W-1:0] current_sample;
		logic [SAMPLE_W-1:0] resistance_sample;
	} sample_t;

	typedef struct packed {
		logic [1:0]           mode;
		logic                 mode_changed;
		logic [READING_W-1:0] reading;
		logic [2:0]           reading_class;
		logic                 buzzer;
	} result_t;

	typedef struct packed {
		logic                start;
		logic [PROD_W-1:0]   dividend;
		logic [SAMPLE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [PROD_W-1:0]   quotient;
		logic [SAMPLE_W-1:0] remainder;
	} div_rsp_t;

endpackage
`default_nettype wire

[rtl/mrc_divider.sv]
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on mrc_pkg for widths and request/response structs.
`default_nettype none
module mrc_divider (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mrc_pkg::div_req_t req,
	output mrc_pkg::div_rsp_t     rsp
);

	logic                           busy_q;
	logic                           done_q;
	logic [mrc_pkg::STEP_W-1:0]     cnt_q;
	logic [mrc_pkg::PROD_W-1:0]     quo_q;
	logic [mrc_pkg::SAMPLE_W-1:0]   rem_q;
	logic [mrc_pkg::SAMPLE_W-1:0]   divisor_q;

	logic [mrc_pkg::SAMPLE_W:0]     shifted;
	logic                           ge;
	logic [mrc_pkg::SAMPLE_W:0]     diff;

	assign shifted = {rem_q, quo_q[mrc_pkg::PROD_W-1]};
	assign ge      = shifted >= {1'b0, divisor_q};
	assign diff    = shifted - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= mrc_pkg::DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == mrc_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			quo_q     <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[mrc_pkg::PROD_W-2:0], ge};
			rem_q <= ge ? diff[mrc_pkg::SAMPLE_W-1:0] : shifted[mrc_pkg::SAMPLE_W-1:0];
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule
`default_nettype wire

[rtl/multimeter_reading_converter_core.sv]
// Top level of the multimeter reading converter: handshakes, registers, sequencer.
// Depends on mrc_pkg and mrc_divider.
//
// One sample transaction is taken at a time. A voltmeter, ammeter or in-range
// ohmmeter reading passes through ST_MUL, which forms the product and starts the
// bit-serial divider, then ST_DIV, which waits for the divider's done flag, then
// ST_FIN, which loads the output register, and back to ST_IDLE, where the next
// sample is taken. No mode or an open ohmmeter sample goes from acceptance straight
// to ST_FIN, skipping the divider. The result sits in an output register, so a new
// sample is taken while the previous result waits; the next result then stalls
// until the waiting one is taken. Register writes are taken at any time, with ready
// tied high; writes should be issued only while the block is idle.
`default_nettype none
module multimeter_reading_converter_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sample_valid,
	output logic                               sample_ready,
	input  wire mrc_pkg::sample_t              sample,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output mrc_pkg::result_t                   result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [mrc_pkg::REF_W-1:0]     cfg_data
);

	mrc_pkg::mrc_state_t state_q, state_d;

	logic [mrc_pkg::REF_W-1:0]    reference_q;
	logic [mrc_pkg::SAMPLE_W-1:0] continuity_q;
	logic [mrc_pkg::SAMPLE_W-1:0] open_limit_q;
	logic [2:0]                   prev_mode_q;

	logic [1:0]                   mode_q;
	logic                         changed_q;
	logic                         open_q;
	logic [mrc_pkg::SAMPLE_W-1:0] sel_q;

	logic                         result_valid_q;
	mrc_pkg::result_t             result_q;

	logic [1:0]                   mode_in;
	logic [mrc_pkg::SAMPLE_W-1:0] sel_in;
	logic                         open_in;
	logic                         accept;
	logic                         slot_free;
	logic                         load_result;

	logic [mrc_pkg::REF_W-1:0]    mul_a;
	logic [mrc_pkg::SAMPLE_W-1:0] mul_b;
	mrc_pkg::div_req_t            div_req;
	mrc_pkg::div_rsp_t            div_rsp;
	mrc_pkg::result_t             result_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reference_q  <= mrc_pkg::REFERENCE_RESET;
			continuity_q <= mrc_pkg::CONTINUITY_RESET;
			open_limit_q <= mrc_pkg::OPEN_LIMIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				mrc_pkg::REG_REFERENCE_OHMS:    reference_q  <= cfg_data;
				mrc_pkg::REG_CONTINUITY_OHMS:   continuity_q <= cfg_data[mrc_pkg::SAMPLE_W-1:0];
				mrc_pkg::REG_OPEN_SAMPLE_LIMIT: open_limit_q <= cfg_data[mrc_pkg::SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// priority: volt, amp, ohm
	always_comb begin
		if (!sample.switch_lines[0]) begin
			mode_in = mrc_pkg::MODE_VOLT;
		end else if (!sample.switch_lines[1]) begin
			mode_in = mrc_pkg::MODE_AMP;
		end else if (!sample.switch_lines[2]) begin
			mode_in = mrc_pkg::MODE_OHM;
		end else begin
			mode_in = mrc_pkg::MODE_NONE;
		end
	end

	always_comb begin
		case (mode_in)
			mrc_pkg::MODE_VOLT: sel_in = sample.voltage_sample;
			mrc_pkg::MODE_AMP:  sel_in = sample.current_sample;
			default:            sel_in = sample.resistance_sample;
		endcase
	end

	assign open_in = (sample.resistance_sample == '0)
		|| (sample.resistance_sample <= open_limit_q);
	assign accept  = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mode_q <= mrc_pkg::MODE_UNSEEN;
		end else if (accept) begin
			prev_mode_q <= {1'b0, mode_in};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q    <= mode_in;
			changed_q <= {1'b0, mode_in} != prev_mode_q;
			open_q    <= open_in;
			sel_q     <= sel_in;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mrc_pkg::ST_IDLE: begin
				if (accept) begin
					if (mode_in == mrc_pkg::MODE_NONE
						|| (mode_in == mrc_pkg::MODE_OHM && open_in)) begin
						state_d = mrc_pkg::ST_FIN;
					end else begin
						state_d = mrc_pkg::ST_MUL;
					end
				end
			end
			mrc_pkg::ST_MUL: state_d = mrc_pkg::ST_DIV;
			mrc_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = mrc_pkg::ST_FIN;
				end
			end
			mrc_pkg::ST_FIN: begin
				if (slot_free) begin
					state_d = mrc_pkg::ST_IDLE;
				end
			end
			default: state_d = mrc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// outputs of the sequencer
	assign slot_free = !result_valid_q || result_ready;

	always_comb begin
		sample_ready  = 1'b0;
		div_req.start = 1'b0;
		load_result   = 1'b0;
		case (state_q)
			mrc_pkg::ST_IDLE: sample_ready  = 1'b1;
			mrc_pkg::ST_MUL:  div_req.start = 1'b1;
			mrc_pkg::ST_FIN:  load_result   = slot_free;
			default: ;
		endcase
	end

	always_comb begin
		case (mode_q)
			mrc_pkg::MODE_VOLT: begin
				mul_a = mrc_pkg::VOLT_GAIN;
				mul_b = sel_q;
			end
			mrc_pkg::MODE_AMP: begin
				mul_a = mrc_pkg::AMP_GAIN;
				mul_b = sel_q;
			end
			default: begin
				mul_a = reference_q;
				mul_b = mrc_pkg::FULL_SCALE - sel_q;
			end
		endcase
	end

	assign div_req.dividend = mrc_pkg::PROD_W'(mul_a) * mrc_pkg::PROD_W'(mul_b);
	assign div_req.divisor  = (mode_q == mrc_pkg::MODE_OHM) ? sel_q : mrc_pkg::FULL_SCALE;

	mrc_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		result_d.mode          = mode_q;
		result_d.mode_changed  = changed_q;
		result_d.reading       = '0;
		result_d.reading_class = mrc_pkg::CLASS_NONE;
		result_d.buzzer        = 1'b0;
		case (mode_q)
			mrc_pkg::MODE_VOLT, mrc_pkg::MODE_AMP: begin
				result_d.reading       = div_rsp.quotient[mrc_pkg::READING_W-1:0];
				result_d.reading_class = mrc_pkg::CLASS_PLAIN;
			end
			mrc_pkg::MODE_OHM: begin
				if (open_q) begin
					result_d.reading       = mrc_pkg::READING_MAX;
					result_d.reading_class = mrc_pkg::CLASS_OPEN;
				end else begin
					result_d.reading = (div_rsp.quotient > mrc_pkg::READING_MAX_Q)
						? mrc_pkg::READING_MAX
						: div_rsp.quotient[mrc_pkg::READING_W-1:0];
					// exact ratio compare from quotient and remainder
					if (div_rsp.quotient < mrc_pkg::PROD_W'(continuity_q)) begin
						result_d.reading_class = mrc_pkg::CLASS_SHORT;
						result_d.buzzer        = 1'b1;
					end else if (div_rsp.quotient > mrc_pkg::OPEN_ABOVE
						|| (div_rsp.quotient == mrc_pkg::OPEN_ABOVE
						&& div_rsp.remainder != '0)) begin
						result_d.reading_class = mrc_pkg::CLASS_OPEN;
					end else if (div_rsp.quotient > mrc_pkg::KILO_ABOVE
						|| (div_rsp.quotient == mrc_pkg::KILO_ABOVE
						&& div_rsp.remainder != '0)) begin
						result_d.reading_class = mrc_pkg::CLASS_KILO;
					end else begin
						result_d.reading_class = mrc_pkg::CLASS_OHM;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_result) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_start_idle_divider: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_result |-> (!result_valid_q || result_ready))
		else $error("pending result overwritten");

	a_none_is_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.mode == mrc_pkg::MODE_NONE)
		|-> (result.reading == '0 && result.reading_class == mrc_pkg::CLASS_NONE))
		else $error("no-mode result carries a reading");

	a_buzzer_short: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.buzzer)
		|-> (result.mode == mrc_pkg::MODE_OHM
		&& result.reading_class == mrc_pkg::CLASS_SHORT))
		else $error("buzzer without ohmmeter short");

endmodule
`default_nettype wire
